FILE: hdl/bitmap_stack_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// Bitmap stack slot allocator assertion macros
// Concurrent assertion wrappers; defining NO_ASSERTIONS turns them into nothing.
// ----------------------------------------------------------------------------
`ifndef BITMAP_STACK_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_STACK_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define BSSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BSSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BSSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/bssa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap stack slot allocator package
// Field widths, register indexes, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package bssa_pkg;

  localparam int WORD_W          = 64;
  localparam int BIT_IDX_W       = 6;
  localparam int SLOTS_PER_GROUP = 512;
  localparam int WORDS_PER_GROUP = SLOTS_PER_GROUP / WORD_W;

  localparam int ADDR_W       = 64;
  localparam int STACK_SIZE_W = 21;
  localparam int HEAP_SIZE_W  = 41;
  localparam int STATUS_W     = 2;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [STACK_SIZE_W-1:0] STACK_SIZE_RST = STACK_SIZE_W'(16384);

  localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STACK_SIZE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_SIZE  = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FREED     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_REJECTED  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_MUL,
    S_A_ADD,
    S_F_SUB,
    S_F_CHK,
    S_F_DIV,
    S_F_RD,
    S_F_WR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/bssa_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap stack slot allocator channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bssa_in_if;
  import bssa_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] stack_address;

  modport source (output valid, output func, output stack_address, input ready);
  modport sink   (input valid, input func, input stack_address, output ready);
endinterface

interface bssa_out_if;
  import bssa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   result_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output result_address, output status, input ready);
  modport sink   (input valid, input result_address, input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/bitmap_stack_slot_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap stack slot allocator
// Hands out and takes back fixed-size stack slots tracked in a used-bit memory.
// ----------------------------------------------------------------------------
// Usage:
// A word on in_ch asks to allocate (func 0) or free (func 1) a stack slot.
// Each request gives exactly one word on out_ch: the slot address and status.
// Requests are handled one at a time; in_ch.ready is high only while idle.
// An allocate scans the used-bit memory one word at a time (one read, one
// check), then steps through the address multiply, add and result load;
// when the bitmap is full it ends after checking the last word.
// A free runs the offset subtract and bounds check, then a one-bit-per-cycle
// divider for Q quotient bits (Q is 10 for one group), then a read and a
// clear of the used bit; a rejected free ends after the bounds check.
// The result sits in an output register, so the next request can be taken
// while out_ch is stalled; a second result waits until the first is taken.
// Reset clears every used bit through per-word valid flags (no clearing
// pass) and loads the configuration registers with their reset values.
// Configuration must be written through cfg_we/cfg_index/cfg_wdata while
// idle, by the user; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "bitmap_stack_slot_allocator_defines.svh"

module bitmap_stack_slot_allocator #(
  parameter int NUM_GROUPS = 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bssa_in_if.sink                              in_ch,
  bssa_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [bssa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bssa_pkg::ADDR_W-1:0]      cfg_wdata
);
  import bssa_pkg::*;

  localparam int DEPTH       = NUM_GROUPS * WORDS_PER_GROUP;
  localparam int TOTAL_SLOTS = NUM_GROUPS * SLOTS_PER_GROUP;
  localparam int WIDX_W      = $clog2(DEPTH);
  localparam int SLOT_W      = WIDX_W + BIT_IDX_W;
  localparam int QW          = $clog2(TOTAL_SLOTS + 1);
  localparam int REM_W       = QW + STACK_SIZE_W;
  localparam int CNT_W       = $clog2(QW);

  localparam logic [QW-1:0]     LIMIT_MULT = QW'(TOTAL_SLOTS + 1);
  localparam logic [QW-1:0]     QUOT_MAX   = QW'(TOTAL_SLOTS);
  localparam logic [WIDX_W-1:0] LAST_WORD  = WIDX_W'(DEPTH - 1);

  // Lowest clear bit of a word that is known not to be all ones.
  function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [BIT_IDX_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) r = BIT_IDX_W'(i);
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]       heap_base_r;
  logic [STACK_SIZE_W-1:0] stack_size_r;
  logic [HEAP_SIZE_W-1:0]  heap_size_r;

  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [ADDR_W-1:0]    off_r, off_nxt;
  logic                 base_ok_r, base_ok_nxt;
  logic [WIDX_W-1:0]    widx_r, widx_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic [REM_W-1:0]     mul_r, mul_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [REM_W-1:0]     dsr_r, dsr_nxt;
  logic [QW-1:0]        quot_r, quot_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic [STATUS_W-1:0]  res_stat_r, res_stat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [STATUS_W-1:0]  out_stat_r, out_stat_nxt;

  // Used-bit memory; a word whose valid flag is clear reads as all free.
  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic              mem_we;
  logic [WIDX_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic                 in_acc;
  logic                 out_load;
  logic [WORD_W-1:0]    word_eff;
  logic                 word_full;
  logic [BIT_IDX_W-1:0] zero_bit;
  logic [QW-1:0]        mul_a;
  logic [REM_W-1:0]     mul_p;
  logic [QW-1:0]        free_slot;
  logic [WIDX_W-1:0]    free_widx;
  logic                 rem_ge;
  logic                 f_reject;

  assign in_acc    = in_ch.valid && (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign word_eff  = rd_vld_r ? rd_data_r : '0;
  assign word_full = &word_eff;
  assign zero_bit  = first_zero(word_eff);
  assign mul_a     = (state_r == S_A_MUL) ? (QW'({widx_r, bit_r}) + QW'(1)) : LIMIT_MULT;
  assign mul_p     = REM_W'(mul_a) * REM_W'(stack_size_r);
  assign free_slot = quot_r - QW'(1);
  assign free_widx = free_slot[SLOT_W-1:BIT_IDX_W];
  assign rem_ge    = (rem_r >= dsr_r);
  assign mem_raddr = (state_r == S_F_RD) ? free_widx : widx_r;

  // A quotient of zero or above the slot count is caught by the bounds on
  // the offset, so the divider only ever produces a valid slot number.
  assign f_reject = !base_ok_r
                 || (off_r >= ADDR_W'(heap_size_r))
                 || (stack_size_r == '0)
                 || (off_r >= ADDR_W'(mul_r))
                 || (off_r < ADDR_W'(stack_size_r));

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.status         = out_stat_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = (in_ch.func == FUNC_ALLOC) ? S_A_RD : S_F_SUB;
      end
      S_A_RD:  state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (!word_full) state_nxt = S_A_MUL;
        else if (widx_r == LAST_WORD) state_nxt = S_DONE;
        else state_nxt = S_A_RD;
      end
      S_A_MUL: state_nxt = S_A_ADD;
      S_A_ADD: state_nxt = S_DONE;
      S_F_SUB: state_nxt = S_F_CHK;
      S_F_CHK: state_nxt = f_reject ? S_DONE : S_F_DIV;
      S_F_DIV: begin
        if (cnt_r == '0) state_nxt = S_F_RD;
      end
      S_F_RD:  state_nxt = S_F_WR;
      S_F_WR:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    addr_nxt      = addr_r;
    off_nxt       = off_r;
    base_ok_nxt   = base_ok_r;
    widx_nxt      = widx_r;
    bit_nxt       = bit_r;
    mul_nxt       = mul_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    quot_nxt      = quot_r;
    cnt_nxt       = cnt_r;
    res_addr_nxt  = res_addr_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    mem_we        = 1'b0;
    mem_wdata     = word_eff;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          addr_nxt = in_ch.stack_address;
          widx_nxt = '0;
        end
      end
      S_A_CHK: begin
        if (!word_full) begin
          bit_nxt   = zero_bit;
          mem_we    = 1'b1;
          mem_wdata = word_eff | (WORD_W'(1) << zero_bit);
        end else if (widx_r == LAST_WORD) begin
          res_addr_nxt = '0;
          res_stat_nxt = STAT_FULL;
        end else begin
          widx_nxt = widx_r + WIDX_W'(1);
        end
      end
      S_A_MUL: mul_nxt = mul_p;
      S_A_ADD: begin
        res_addr_nxt = heap_base_r + ADDR_W'(mul_r);
        res_stat_nxt = STAT_ALLOCATED;
      end
      S_F_SUB: begin
        off_nxt     = addr_r - heap_base_r;
        base_ok_nxt = (addr_r >= heap_base_r);
        mul_nxt     = mul_p;
      end
      S_F_CHK: begin
        if (f_reject) begin
          res_addr_nxt = '0;
          res_stat_nxt = STAT_REJECTED;
        end else begin
          rem_nxt  = off_r[REM_W-1:0];
          dsr_nxt  = REM_W'(stack_size_r) << (QW - 1);
          quot_nxt = '0;
          cnt_nxt  = CNT_W'(QW - 1);
        end
      end
      S_F_DIV: begin
        if (rem_ge) rem_nxt = rem_r - dsr_r;
        quot_nxt = {quot_r[QW-2:0], rem_ge};
        dsr_nxt  = dsr_r >> 1;
        cnt_nxt  = cnt_r - CNT_W'(1);
      end
      S_F_RD: begin
        widx_nxt = free_widx;
        bit_nxt  = free_slot[BIT_IDX_W-1:0];
      end
      S_F_WR: begin
        mem_we       = 1'b1;
        mem_wdata    = word_eff & ~(WORD_W'(1) << bit_r);
        res_addr_nxt = '0;
        res_stat_nxt = STAT_FREED;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_stat_nxt  = res_stat_r;
        end
      end
      default: ;
    endcase
  end

  // Requests run strictly one after another, so a write always lands
  // before the next read of the same word.
  always_ff @(posedge clk) begin
    if (mem_we) mem[widx_r] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_base_r  <= '0;
      stack_size_r <= STACK_SIZE_RST;
      heap_size_r  <= '0;
      vld_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= vld_r[mem_raddr];
      if (mem_we) vld_r[widx_r] <= 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAP_BASE:  heap_base_r  <= cfg_wdata;
          CFG_STACK_SIZE: stack_size_r <= cfg_wdata[STACK_SIZE_W-1:0];
          CFG_HEAP_SIZE:  heap_size_r  <= cfg_wdata[HEAP_SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    off_r      <= off_nxt;
    base_ok_r  <= base_ok_nxt;
    widx_r     <= widx_nxt;
    bit_r      <= bit_nxt;
    mul_r      <= mul_nxt;
    rem_r      <= rem_nxt;
    dsr_r      <= dsr_nxt;
    quot_r     <= quot_nxt;
    cnt_r      <= cnt_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  `BSSA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "request accepted while busy")
  `BSSA_ASSERT_IMPL(a_free_addr_zero, clk, rst_n, out_valid_r && (out_stat_r == STAT_FREED || out_stat_r == STAT_REJECTED), out_addr_r == '0, "free result with nonzero address")
  `BSSA_ASSERT_IMPL(a_write_states, clk, rst_n, mem_we, state_r == S_A_CHK || state_r == S_F_WR, "bitmap write outside an update state")
  `BSSA_ASSERT_IMPL(a_quot_range, clk, rst_n, state_r == S_F_RD, quot_r != '0 && quot_r <= QUOT_MAX, "divider quotient out of slot range")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap stack slot allocator testbench
// Drives allocate and free words under random source gaps and sink stalls.
// Each accepted request is run through a local copy of the slot bitmap and
// the configuration. The returned words are compared in order with the
// predicted address and status. Directed corner cases come first, followed
// by random phases that refill, drain and re-configure the slot region.
// ----------------------------------------------------------------------------
module tb;
  import bssa_pkg::*;

  localparam int NUM_GROUPS = 1;
  localparam int SLOT_COUNT = NUM_GROUPS * SLOTS_PER_GROUP;
  localparam int IDLE_GUARD = 32;
  localparam int RUN_LIMIT  = 2_000_000;
  localparam int PHASES     = 6;

  // The index above the last register; the block must ignore writes to it.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
  } slot_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]      cfg_wdata;

  bssa_in_if  req_if ();
  bssa_out_if res_if ();

  bitmap_stack_slot_allocator #(
    .NUM_GROUPS(NUM_GROUPS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_if),
    .out_ch   (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Local copy of the block's state and registers.
  logic [SLOT_COUNT-1:0]   used_map;
  logic [ADDR_W-1:0]       base_reg;
  logic [STACK_SIZE_W-1:0] stack_reg;
  logic [HEAP_SIZE_W-1:0]  hsize_reg;

  request_t     request_q[$];
  slot_result_t outcome_q[$];

  int idle_pct = 16;
  int bad_words = 0;
  int n_requests = 0;
  int n_settings = 0;
  int n_allocated = 0;
  int n_full = 0;
  int n_freed = 0;
  int n_refused = 0;

  int phase_len [PHASES] = '{300, 600, 300, 300, 300, 220};
  int alloc_pct [PHASES] = '{60, 97, 30, 70, 50, 85};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the local bitmap and returns the word it yields.
  function automatic slot_result_t slot_outcome(input logic func,
                                                input logic [ADDR_W-1:0] addr);
    slot_result_t r;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] quot;
    int slot;
    r.address = '0;
    r.status  = STAT_REJECTED;
    if (func == FUNC_ALLOC) begin
      slot = -1;
      for (int s = 0; s < SLOT_COUNT; s++)
        if (slot < 0 && !used_map[s]) slot = s;
      if (slot < 0) begin
        r.status = STAT_FULL;
      end else begin
        used_map[slot] = 1'b1;
        r.address = base_reg + 64'(slot + 1) * {43'd0, stack_reg};
        r.status  = STAT_ALLOCATED;
      end
    end else if (addr >= base_reg) begin
      offset = addr - base_reg;
      if (offset < {23'd0, hsize_reg} && stack_reg != '0) begin
        quot = offset / {43'd0, stack_reg};
        if (quot != 0 && quot <= SLOT_COUNT) begin
          used_map[int'(quot) - 1] = 1'b0;
          r.status = STAT_FREED;
        end
      end
    end
    return r;
  endfunction

  function automatic void queue_request(input logic func, input logic [ADDR_W-1:0] addr);
    request_t q;
    q.func    = func;
    q.address = addr;
    request_q.push_back(q);
  endfunction

  // Half the time an address in a slot near the bottom, where slots tend to be in use.
  function automatic logic [ADDR_W-1:0] free_address();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] slot_off;
    int unsigned k;
    k = $urandom_range(0, $urandom_range(0, SLOT_COUNT - 1));
    slot_off = (stack_reg > 1) ? 64'($urandom_range(0, int'(stack_reg) - 1)) : '0;
    case ($urandom_range(0, 9))
      0, 1: a = {$urandom(), $urandom()};
      2: a = base_reg - 64'($urandom_range(1, 64));
      3: a = base_reg + {23'd0, hsize_reg} + 64'($urandom_range(0, 3));
      4: a = base_reg + slot_off;
      5, 6: a = base_reg + 64'(k + 1) * {43'd0, stack_reg};
      default: a = base_reg + 64'(k + 1) * {43'd0, stack_reg} + slot_off;
    endcase
    return a;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEAP_BASE:  base_reg  = val;
      CFG_STACK_SIZE: stack_reg = val[STACK_SIZE_W-1:0];
      CFG_HEAP_SIZE:  hsize_reg = val[HEAP_SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || req_if.valid || outcome_q.size() != 0)
      @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  // Request driver.
  always @(posedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        outcome_q.push_back(slot_outcome(req_if.func, req_if.stack_address));
        n_requests++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = request_q.pop_front();
          req_if.valid         <= 1'b1;
          req_if.func          <= nxt.func;
          req_if.stack_address <= nxt.address;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    slot_result_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        case (res_if.status)
          STAT_ALLOCATED: n_allocated++;
          STAT_FULL:      n_full++;
          STAT_FREED:     n_freed++;
          default:        n_refused++;
        endcase
        if (outcome_q.size() == 0) begin
          $display("%0t: result word with nothing expected: address %h status %0d",
                   $time, res_if.result_address, res_if.status);
          bad_words++;
        end else begin
          want = outcome_q.pop_front();
          if (res_if.result_address !== want.address) begin
            $display("%0t: address expected %h, got %h",
                     $time, want.address, res_if.result_address);
            bad_words++;
          end
          if (res_if.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, res_if.status);
            bad_words++;
          end
        end
      end
      res_if.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  initial begin
    logic [ADDR_W-1:0]       junk;
    logic [ADDR_W-1:0]       span;
    logic [ADDR_W-1:0]       base;
    logic [STACK_SIZE_W-1:0] ss;
    logic [HEAP_SIZE_W-1:0]  hs;

    req_if.valid         = 1'b0;
    req_if.func          = FUNC_ALLOC;
    req_if.stack_address = '0;
    res_if.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_HEAP_BASE;
    cfg_wdata            = '0;
    rst_n                = 1'b0;
    used_map             = '0;
    base_reg             = '0;
    stack_reg            = STACK_SIZE_RST;
    hsize_reg            = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: a heap size of zero refuses every free.
    queue_request(FUNC_ALLOC, '1);
    queue_request(FUNC_ALLOC, '0);
    queue_request(FUNC_FREE, 64'd16384);
    queue_request(FUNC_FREE, 64'd32768);
    wait_idle();
    n_settings++;

    // Sixteen-byte slots at 0x1000; the upper data bits must be dropped.
    write_reg(CFG_HEAP_BASE, 64'h1000);
    write_reg(CFG_STACK_SIZE, 64'hFFFF_FFFF_FFE0_0010);
    write_reg(CFG_HEAP_SIZE, 64'hFFFF_FE00_0000_0000 | 64'(16 * 514));
    write_reg(CFG_UNUSED, '1);
    n_settings++;
    repeat (3) queue_request(FUNC_ALLOC, '0);
    queue_request(FUNC_FREE, 64'h0FFF);                  // below the base
    queue_request(FUNC_FREE, 64'h1000);                  // quotient of zero
    queue_request(FUNC_FREE, 64'h100F);
    queue_request(FUNC_FREE, 64'h1017);                  // unaligned, first slot
    queue_request(FUNC_FREE, 64'h1010);                  // already clear
    queue_request(FUNC_FREE, 64'h1000 + 16 * 513);       // one past the last slot
    queue_request(FUNC_FREE, 64'h1000 + 16 * 514 - 1);
    queue_request(FUNC_FREE, 64'h1000 + 16 * 514);       // end of the region
    queue_request(FUNC_FREE, '1);
    queue_request(FUNC_FREE, '0);
    queue_request(FUNC_ALLOC, '1);                       // lowest clear slot again
    wait_idle();

    // A zero slot size returns the base and refuses every free.
    write_reg(CFG_STACK_SIZE, '0);
    n_settings++;
    queue_request(FUNC_ALLOC, '0);
    queue_request(FUNC_FREE, 64'h1010);
    wait_idle();

    // Base near the top with the widest slot size: addresses wrap around.
    write_reg(CFG_HEAP_BASE, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(CFG_STACK_SIZE, '1);
    write_reg(CFG_HEAP_SIZE, '1);
    n_settings++;
    queue_request(FUNC_ALLOC, '0);
    queue_request(FUNC_ALLOC, '0);
    queue_request(FUNC_FREE, 64'hFFFF_FFFF_FFFF_0000 + 64'h3F_FFFE);
    queue_request(FUNC_FREE, '1);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: base = '0;
        1: base = {$urandom(), $urandom()};
        2: base = '1 - 64'($urandom_range(0, 1 << 20));
        default: base = 64'($urandom());
      endcase
      case ($urandom_range(0, 5))
        0: ss = 21'd1;
        1: ss = 21'($urandom_range(2, 64));
        2: ss = 21'd1 << $urandom_range(0, 20);
        3: ss = 21'($urandom_range(1, 1 << 20));
        4: ss = 21'(1 << 20);
        default: ss = '1;
      endcase
      span = 64'(SLOT_COUNT + $urandom_range(0, 2)) * {43'd0, ss}
             + 64'($urandom_range(0, int'(ss) - 1));
      case ($urandom_range(0, 9))
        0: hs = '0;
        1: hs = '1;
        2: hs = 41'($urandom_range(0, 1 << 20));
        default: hs = span[HEAP_SIZE_W-1:0];
      endcase
      junk = {$urandom(), $urandom()};
      write_reg(CFG_HEAP_BASE, base);
      write_reg(CFG_STACK_SIZE, {junk[ADDR_W-1:STACK_SIZE_W], ss});
      write_reg(CFG_HEAP_SIZE, {junk[ADDR_W-1:HEAP_SIZE_W], hs});
      write_reg(CFG_UNUSED, junk);
      n_settings++;
      // One phase runs with no gaps and no stalls at all.
      idle_pct = (p == 3) ? 0 : 16;
      repeat (phase_len[p]) begin
        if ($urandom_range(0, 99) < alloc_pct[p])
          queue_request(FUNC_ALLOC, {$urandom(), $urandom()});
        else
          queue_request(FUNC_FREE, free_address());
      end
      wait_idle();
    end

    $display("Ran %0d requests over %0d register settings.", n_requests, n_settings);
    $display("Words: %0d allocated, %0d full, %0d freed, %0d frees refused.",
             n_allocated, n_full, n_freed, n_refused);
    if (bad_words == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("Run limit reached with %0d result words outstanding.", outcome_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
